// ===== hdl/ptpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Phase term phasor generator package
// Shared types, codes, constants and arithmetic helpers.
// ----------------------------------------------------------------------------
package ptpg_pkg;

	localparam int MAX_POINTS_DEF    = 4096;
	localparam int CORDIC_STAGES_DEF = 30;
	localparam int STAGE_W           = 5;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic REG_FREQ_STEP  = 1'b0;
	localparam logic REG_NUM_POINTS = 1'b1;

	localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [63:0]        INV_TWO_PI  = 64'h28BE60DB9391054A;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIMB,
		ST_CINIT,
		ST_CITER,
		ST_CDONE,
		ST_CMUL,
		ST_CFIN
	} state_t;

	typedef struct packed {
		logic               load_start;
		logic               step_emit;
		logic               limb_en;
		logic               limb_first;
		logic [1:0]         scal_sel;
		logic               cap_sph;
		logic               cord_init;
		logic               cord_sel;
		logic               cord_iter;
		logic [STAGE_W-1:0] stage;
		logic               cord_done;
		logic               run_start;
		logic               mul_en;
		logic [1:0]         mul_idx;
		logic               mul_fin;
	} dp_cmd_t;

	typedef struct packed {
		logic run_active;
		logic out_free;
	} dp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] round_q30(input logic signed [65:0] v);
		logic signed [65:0] t;
		t = (v + 66'sd536870912) >>> 30;
		return sat32(t);
	endfunction

	function automatic logic [31:0] atan_turns(input logic [STAGE_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/phase_term_phasor_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Phase term phasor generator
// Recursive quadrature oscillator: a load forms the step and half phasors by
// CORDIC, each step emits the current phasor and advances it by a complex multiply.
// ----------------------------------------------------------------------------
// Channel | Direction | Beat contents
// s_*     | in        | tuser: cmd; tdata: thickness [23:0], slowness [51:24]
// m_*     | out       | tdata: re_part, im_part, freq_index; tlast: last
// cfg_*   | in        | index 0 freq_step, index 1 num_points
//
// A load beat runs the limb multiplication and then two passes of the
// single iterative CORDIC unit, for the step and the half phasor.
// A step beat makes four passes through one 32 by 32 multiplier and a
// rounding step; a step with no run loaded is taken and gives no result.
// Reset clears control and run state at once, not work registers; no clearing pass.
// Input is held off while the output register holds a beat not yet taken.
// ----------------------------------------------------------------------------
module phase_term_phasor_generator_unit import ptpg_pkg::*; #(
	parameter int MAX_POINTS    = MAX_POINTS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // thickness [23:0], slowness [51:24]
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // re_part [31:0], im_part [63:32], freq_index [75:64]
	output logic        m_tlast
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	ptpg_ctrl #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptpg_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

`ifndef NO_ASSERTIONS
	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == CMD_STEP))
		else $error("Result beat appeared without an accepted step beat.");

	a_idle_step_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == CMD_STEP && !sts.run_active)
		|=> !$rose(m_tvalid))
		else $error("Step beat with no run loaded produced a result.");
`endif

endmodule

// ===== hdl/ptpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Phase term phasor generator controller
// Sequences the limb multiplier, the CORDIC and the complex multiply.
// ----------------------------------------------------------------------------
module ptpg_ctrl import ptpg_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  logic    s_tuser,
	output logic    s_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t             state_q, state_d;
	logic [2:0]         limb_q, limb_d;
	logic [1:0]         pass_q, pass_d;
	logic [STAGE_W-1:0] stage_q, stage_d;
	logic               sel_q, sel_d;
	logic [1:0]         mcnt_q, mcnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limb_q  <= '0;
			pass_q  <= '0;
			stage_q <= '0;
			sel_q   <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			limb_q  <= limb_d;
			pass_q  <= pass_d;
			stage_q <= stage_d;
			sel_q   <= sel_d;
			mcnt_q  <= mcnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		limb_d   = limb_q;
		pass_d   = pass_q;
		stage_d  = stage_q;
		sel_d    = sel_q;
		mcnt_d   = mcnt_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.scal_sel = pass_q;
		cmd.stage    = stage_q;
		cmd.cord_sel = sel_q;
		cmd.mul_idx  = mcnt_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = sts.out_free;
				if (s_tvalid && sts.out_free) begin
					if (s_tuser == CMD_LOAD) begin
						cmd.load_start = 1'b1;
						limb_d  = '0;
						pass_d  = '0;
						state_d = ST_LIMB;
					end else if (sts.run_active) begin
						cmd.step_emit = 1'b1;
						mcnt_d  = '0;
						state_d = ST_CMUL;
					end
				end
			end
			ST_LIMB: begin
				cmd.limb_en    = 1'b1;
				cmd.limb_first = (limb_q == 3'd0);
				cmd.cap_sph    = (pass_q == 2'd3) && (limb_q == 3'd0);
				if (limb_q == 3'd5) begin
					limb_d = '0;
					if (pass_q == 2'd3) begin
						sel_d   = 1'b0;
						state_d = ST_CINIT;
					end else begin
						pass_d = pass_q + 2'd1;
					end
				end else begin
					limb_d = limb_q + 3'd1;
				end
			end
			ST_CINIT: begin
				cmd.cord_init = 1'b1;
				stage_d = '0;
				state_d = ST_CITER;
			end
			ST_CITER: begin
				cmd.cord_iter = 1'b1;
				if (stage_q == STAGE_W'(CORDIC_STAGES - 1)) begin
					state_d = ST_CDONE;
				end else begin
					stage_d = stage_q + 1'b1;
				end
			end
			ST_CDONE: begin
				cmd.cord_done = 1'b1;
				if (sel_q) begin
					cmd.run_start = 1'b1;
					state_d = ST_IDLE;
				end else begin
					sel_d   = 1'b1;
					state_d = ST_CINIT;
				end
			end
			ST_CMUL: begin
				cmd.mul_en = 1'b1;
				mcnt_d = mcnt_q + 2'd1;
				if (mcnt_q == 2'd3) begin
					state_d = ST_CFIN;
				end
			end
			ST_CFIN: begin
				cmd.mul_fin = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/ptpg_dp.sv =====
// ----------------------------------------------------------------------------
// Phase term phasor generator datapath
// Limb multiplier for the phase, iterative CORDIC, complex multiply and the
// output register.
// ----------------------------------------------------------------------------
module ptpg_dp import ptpg_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [55:0] s_tdata,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,
	output logic        m_tlast
);

	localparam int PW = $clog2(MAX_POINTS + 1);

	logic [31:0]        freq_step_q;
	logic [12:0]        num_points_q;
	logic [23:0]        thick_q;
	logic [28:0]        mag_q;
	logic               neg_q;
	logic [191:0]       acc_q;
	logic [31:0]        carry_q;
	logic [31:0]        sph_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [1:0]         quad_q;
	logic signed [31:0] step_re_q, step_im_q, half_re_q, half_im_q;
	logic signed [31:0] cur_re_q, cur_im_q;
	logic [PW-1:0]      k_q;
	logic               active_q, last_q;
	logic signed [65:0] macc_q;
	logic signed [31:0] nr_q;
	logic               ovalid_q;
	logic signed [31:0] ore_q, oim_q;
	logic [11:0]        oidx_q;
	logic               olast_q;

	logic [PW-1:0]      eff_n, half_n;
	logic [27:0]        raw;
	logic [31:0]        scal, cin, hph, ph, ph_off, dlt;
	logic [63:0]        lt;
	logic signed [33:0] dx, dy, at;
	logic signed [34:0] xe, ye;
	logic signed [31:0] c_o, s_o;
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [65:0] pe;
	logic               use_half;

	always_comb begin
		if (num_points_q < 13'd2) begin
			eff_n = PW'(2);
		end else if (32'(num_points_q) > 32'(MAX_POINTS)) begin
			eff_n = PW'(MAX_POINTS);
		end else begin
			eff_n = PW'(num_points_q);
		end
		half_n = eff_n >> 1;
	end

	assign raw = s_tdata[51:24];

	always_comb begin
		case (cmd.scal_sel)
			2'd0:    scal = freq_step_q;
			2'd1:    scal = {8'b0, thick_q};
			2'd2:    scal = {3'b0, mag_q};
			default: scal = 32'(half_n);
		endcase
		cin = cmd.limb_first ? 32'd0 : carry_q;
		lt  = {32'b0, acc_q[31:0]} * {32'b0, scal} + {32'b0, cin};
	end

	assign hph    = neg_q ? (32'd0 - acc_q[127:96]) : acc_q[127:96];
	assign ph     = cmd.cord_sel ? hph : sph_q;
	assign ph_off = ph + 32'h20000000;
	assign dlt    = ph - {ph_off[31:30], 30'b0};

	assign dx = cy_q >>> cmd.stage;
	assign dy = cx_q >>> cmd.stage;
	assign at = $signed({2'b00, atan_turns(cmd.stage)});

	assign xe = {cx_q[33], cx_q};
	assign ye = {cy_q[33], cy_q};

	always_comb begin
		case (quad_q)
			2'd0: begin
				c_o = sat32(66'(xe));
				s_o = sat32(66'(ye));
			end
			2'd1: begin
				c_o = sat32(66'(-ye));
				s_o = sat32(66'(xe));
			end
			2'd2: begin
				c_o = sat32(66'(-xe));
				s_o = sat32(66'(-ye));
			end
			default: begin
				c_o = sat32(66'(ye));
				s_o = sat32(66'(-xe));
			end
		endcase
	end

	assign ma   = (cmd.mul_idx == 2'd0 || cmd.mul_idx == 2'd3) ? cur_re_q : cur_im_q;
	assign mb   = (cmd.mul_idx == 2'd0 || cmd.mul_idx == 2'd2) ? step_re_q : step_im_q;
	assign prod = ma * mb;
	assign pe   = 66'(prod);

	assign use_half = (k_q == half_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_step_q  <= '0;
			num_points_q <= 13'd1024;
			step_re_q    <= ONE_Q30;
			step_im_q    <= '0;
			half_re_q    <= ONE_Q30;
			half_im_q    <= '0;
			cur_re_q     <= ONE_Q30;
			cur_im_q     <= '0;
			k_q          <= '0;
			active_q     <= 1'b0;
			ovalid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FREQ_STEP:  freq_step_q  <= cfg_data;
					REG_NUM_POINTS: num_points_q <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (cmd.cord_done) begin
				if (cmd.cord_sel) begin
					half_re_q <= c_o;
					half_im_q <= s_o;
				end else begin
					step_re_q <= c_o;
					step_im_q <= s_o;
				end
			end
			if (cmd.run_start) begin
				cur_re_q <= ONE_Q30;
				cur_im_q <= '0;
				k_q      <= '0;
				active_q <= 1'b1;
			end
			if (cmd.step_emit && use_half) begin
				cur_re_q <= half_re_q;
				cur_im_q <= half_im_q;
			end
			if (cmd.mul_fin) begin
				cur_re_q <= nr_q;
				cur_im_q <= round_q30(macc_q);
				k_q      <= k_q + 1'b1;
				if (last_q) begin
					active_q <= 1'b0;
				end
			end
			if (cmd.step_emit) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			thick_q <= s_tdata[23:0];
			neg_q   <= raw[27];
			mag_q   <= raw[27] ? (29'h10000000 - {1'b0, raw}) : {1'b0, raw};
			acc_q   <= {128'b0, INV_TWO_PI};
		end else if (cmd.limb_en) begin
			acc_q   <= {lt[31:0], acc_q[191:32]};
			carry_q <= lt[63:32];
		end
		if (cmd.cap_sph) begin
			sph_q <= neg_q ? acc_q[127:96] : (32'd0 - acc_q[127:96]);
		end
		if (cmd.cord_init) begin
			cx_q   <= CORDIC_GAIN;
			cy_q   <= '0;
			cz_q   <= $signed({{2{dlt[31]}}, dlt});
			quad_q <= ph_off[31:30];
		end else if (cmd.cord_iter) begin
			if (!cz_q[33]) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + at;
			end
		end
		if (cmd.mul_en) begin
			case (cmd.mul_idx)
				2'd0: macc_q <= pe;
				2'd1: macc_q <= macc_q - pe;
				2'd2: begin
					nr_q   <= round_q30(macc_q);
					macc_q <= pe;
				end
				default: macc_q <= macc_q + pe;
			endcase
		end
		if (cmd.step_emit) begin
			ore_q   <= use_half ? half_re_q : cur_re_q;
			oim_q   <= use_half ? half_im_q : cur_im_q;
			oidx_q  <= 12'(k_q);
			olast_q <= (k_q >= eff_n - 1'b1);
			last_q  <= (k_q >= eff_n - 1'b1);
		end
	end

	assign sts.run_active = active_q;
	assign sts.out_free   = !ovalid_q || m_tready;
	assign m_tvalid       = ovalid_q;
	assign m_tdata        = {4'b0, oidx_q, oim_q, ore_q};
	assign m_tlast        = olast_q;

endmodule
